@@ hdl/kce_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kce_pkg
// Shared types and constants for the keypad code entry and key check block.
// ----------------------------------------------------------------------------
package kce_pkg;

  typedef enum logic [1:0] {
    CMD_DIGIT,
    CMD_STAR,
    CMD_SHARP,
    CMD_KEY
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIGITS,
    ST_KEY
  } back_state_e;

  localparam logic [1:0] KIND_DIGITS = 2'd0;
  localparam logic [1:0] KIND_KEY    = 2'd1;
  localparam logic [1:0] KIND_ERR    = 2'd2;

  localparam logic [3:0] SYM_DIGIT_MAX = 4'd9;
  localparam logic [3:0] SYM_STAR      = 4'd10;
  localparam logic [3:0] SYM_SHARP     = 4'd11;

  localparam logic [3:0] NIB_MASK = 4'hF;

  localparam logic [0:0] REG_KEY_ERR = 1'b0;

endpackage

`default_nettype wire

@@ hdl/keypad_code_entry_and_key_check.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_code_entry_and_key_check
// Keypad code entry with digit buffering and serial key nibble check.
//
//   channel   direction  tuser        tdata                          tlast
//   s_axis    in         op           symbol[3:0], rx_byte[11:4]     -
//   m_axis    out        kind         value[7:0], length[12:8]       last
//   apb       in/out     -            key_error_code at address 0    -
//
// a result passes the command queue and then the output register after its input transaction
// digit, sharp and key byte transactions are each popped in the idle state, unused symbols never enter the queue
// star with buffered digits then emits one item per digit from ST_DIGITS, an empty star a lone zero marker
// a good key is then emitted byte by byte from ST_KEY, a failed key gives a single error result
// a busy or stalled back end fills the two-entry queue, then tready drops
// reset clears counts, queue and output valid flag; stores need no clearing
// ----------------------------------------------------------------------------
module keypad_code_entry_and_key_check #(
  parameter int DIGITS    = 8,
  parameter int KEY_BYTES = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // symbol[3:0], rx_byte[11:4], zero
  input  wire logic        s_axis_tuser,   // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // value[7:0], length[12:8], zero
  output logic [1:0]       m_axis_tuser,   // kind
  output logic             m_axis_tlast,   // last
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_valid;
  kce_pkg::cmd_t push_cmd;
  kce_pkg::cmd_t head_cmd;
  logic [7:0]    key_error_code_q;
  logic [7:0]    out_value;
  logic [4:0]    out_length;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_error_code_q <= 8'd0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == kce_pkg::REG_KEY_ERR)) begin
      key_error_code_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == kce_pkg::REG_KEY_ERR) ? {24'd0, key_error_code_q} : 32'd0;

  kce_front u_front (
    .in_valid_i   (s_axis_tvalid),
    .in_op_i      (s_axis_tuser),
    .in_symbol_i  (s_axis_tdata[3:0]),
    .in_rx_byte_i (s_axis_tdata[11:4]),
    .q_full_i     (q_full),
    .in_ready_o   (s_axis_tready),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  kce_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  kce_back #(
    .DIGITS    (DIGITS),
    .KEY_BYTES (KEY_BYTES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_cmd_i          (head_cmd),
    .pop_o            (pop),
    .key_error_code_i (key_error_code_q),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_kind_o       (m_axis_tuser),
    .out_value_o      (out_value),
    .out_length_o     (out_length),
    .out_last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_length, out_value};

endmodule

`default_nettype wire

@@ hdl/kce_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kce_front
// Classifies incoming keypad symbols and serial key bytes into commands.
// ----------------------------------------------------------------------------
module kce_front (
  input  wire logic        in_valid_i,
  input  wire logic        in_op_i,
  input  wire logic [3:0]  in_symbol_i,
  input  wire logic [7:0]  in_rx_byte_i,
  input  wire logic        q_full_i,
  output logic             in_ready_o,
  output logic             push_o,
  output kce_pkg::cmd_t    cmd_o
);

  logic keep;

  always_comb begin
    keep        = 1'b1;
    cmd_o.op    = kce_pkg::CMD_DIGIT;
    cmd_o.data  = {4'b0000, in_symbol_i};
    if (in_op_i) begin
      cmd_o.op   = kce_pkg::CMD_KEY;
      cmd_o.data = in_rx_byte_i;
    end else if (in_symbol_i <= kce_pkg::SYM_DIGIT_MAX) begin
      cmd_o.op = kce_pkg::CMD_DIGIT;
    end else if (in_symbol_i == kce_pkg::SYM_STAR) begin
      cmd_o.op = kce_pkg::CMD_STAR;
    end else if (in_symbol_i == kce_pkg::SYM_SHARP) begin
      cmd_o.op = kce_pkg::CMD_SHARP;
    end else begin
      // unused symbol codes are swallowed
      keep = 1'b0;
    end
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i && keep;

endmodule

`default_nettype wire

@@ hdl/kce_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kce_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module kce_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire kce_pkg::cmd_t push_cmd_i,
  input  wire logic          pop_i,
  output logic               full_o,
  output logic               valid_o,
  output kce_pkg::cmd_t      head_o
);

  kce_pkg::cmd_t entry_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = !wptr_q;
    end
    if (pop_i) begin
      rptr_d = !rptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_cmd_i;
    end
  end

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = entry_q[rptr_q];

endmodule

`default_nettype wire

@@ hdl/kce_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kce_back
// Executes commands: digit buffering, message emission, key collection,
// nibble check and key byte emission through an output register.
// ----------------------------------------------------------------------------
module kce_back #(
  parameter int DIGITS    = 8,
  parameter int KEY_BYTES = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire kce_pkg::cmd_t q_cmd_i,
  output logic               pop_o,
  input  wire logic [7:0]    key_error_code_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [1:0]         out_kind_o,
  output logic [7:0]         out_value_o,
  output logic [4:0]         out_length_o,
  output logic               out_last_o
);

  localparam int DIG_CW   = $clog2(DIGITS + 1);
  localparam int DIG_IW   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int RAW      = 2 * KEY_BYTES;
  localparam int KC_W     = $clog2(RAW);
  localparam int KI_W     = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  kce_pkg::back_state_e state_q, state_d;

  logic [3:0]        digit_store_q [DIGITS];
  logic [7:0]        key_store_q   [KEY_BYTES];
  logic [DIG_CW-1:0] dcnt_q, dcnt_d;
  logic [DIG_CW-1:0] dlen_q, dlen_d;
  logic [DIG_IW-1:0] didx_q, didx_d;
  logic [KC_W-1:0]   kcnt_q, kcnt_d;
  logic [KI_W-1:0]   kidx_q, kidx_d;
  logic              ok_q, ok_d;

  logic              out_valid_q;
  logic [1:0]        out_kind_q;
  logic [7:0]        out_value_q;
  logic [4:0]        out_length_q;
  logic              out_last_q;

  logic              can_emit;
  logic              emit;
  logic [1:0]        e_kind;
  logic [7:0]        e_value;
  logic [4:0]        e_length;
  logic              e_last;
  logic              dwe;
  logic              kwe;
  logic              byte_ok;
  logic              ok_now;
  logic [KI_W-1:0]   kwr_idx;

  assign can_emit = !out_valid_q || out_ready_i;
  assign byte_ok  = ((q_cmd_i.data[7:4] ^ q_cmd_i.data[3:0]) == kce_pkg::NIB_MASK);
  assign ok_now   = ((kcnt_q == '0) ? 1'b1 : ok_q) && byte_ok;
  assign kwr_idx  = KI_W'(kcnt_q >> 1);

  always_comb begin
    state_d  = state_q;
    dcnt_d   = dcnt_q;
    dlen_d   = dlen_q;
    didx_d   = didx_q;
    kcnt_d   = kcnt_q;
    kidx_d   = kidx_q;
    ok_d     = ok_q;
    pop_o    = 1'b0;
    emit     = 1'b0;
    dwe      = 1'b0;
    kwe      = 1'b0;
    e_kind   = kce_pkg::KIND_DIGITS;
    e_value  = 8'd0;
    e_length = 5'd0;
    e_last   = 1'b1;
    case (state_q)
      kce_pkg::ST_IDLE: begin
        if (q_valid_i && can_emit) begin
          pop_o = 1'b1;
          case (q_cmd_i.op)
            kce_pkg::CMD_DIGIT: begin
              if (dcnt_q < DIG_CW'(DIGITS)) begin
                dwe    = 1'b1;
                dcnt_d = dcnt_q + 1'b1;
              end
            end
            kce_pkg::CMD_STAR: begin
              if (dcnt_q == '0) begin
                emit = 1'b1;
              end else begin
                dlen_d  = dcnt_q;
                didx_d  = '0;
                state_d = kce_pkg::ST_DIGITS;
              end
              dcnt_d = '0;
            end
            kce_pkg::CMD_SHARP: begin
              dcnt_d = '0;
            end
            kce_pkg::CMD_KEY: begin
              kwe  = 1'b1;
              ok_d = ok_now;
              if (kcnt_q == KC_W'(RAW - 1)) begin
                kcnt_d = '0;
                dcnt_d = '0;
                if (ok_now) begin
                  kidx_d  = '0;
                  state_d = kce_pkg::ST_KEY;
                end else begin
                  emit     = 1'b1;
                  e_kind   = kce_pkg::KIND_ERR;
                  e_value  = key_error_code_i;
                  e_length = 5'd1;
                end
              end else begin
                kcnt_d = kcnt_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      kce_pkg::ST_DIGITS: begin
        if (can_emit) begin
          emit     = 1'b1;
          e_kind   = kce_pkg::KIND_DIGITS;
          e_value  = {4'b0000, digit_store_q[didx_q]};
          e_length = 5'(dlen_q);
          e_last   = ((DIG_CW'(didx_q) + 1'b1) == dlen_q);
          if (e_last) begin
            state_d = kce_pkg::ST_IDLE;
          end else begin
            didx_d = didx_q + 1'b1;
          end
        end
      end
      kce_pkg::ST_KEY: begin
        if (can_emit) begin
          emit     = 1'b1;
          e_kind   = kce_pkg::KIND_KEY;
          e_value  = key_store_q[kidx_q];
          e_length = 5'(KEY_BYTES);
          e_last   = (kidx_q == KI_W'(KEY_BYTES - 1));
          if (e_last) begin
            state_d = kce_pkg::ST_IDLE;
          end else begin
            kidx_d = kidx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = kce_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kce_pkg::ST_IDLE;
      dcnt_q      <= '0;
      dlen_q      <= '0;
      didx_q      <= '0;
      kcnt_q      <= '0;
      kidx_q      <= '0;
      ok_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dcnt_q  <= dcnt_d;
      dlen_q  <= dlen_d;
      didx_q  <= didx_d;
      kcnt_q  <= kcnt_d;
      kidx_q  <= kidx_d;
      ok_q    <= ok_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q   <= e_kind;
      out_value_q  <= e_value;
      out_length_q <= e_length;
      out_last_q   <= e_last;
    end
  end

  // digit store and packed key store
  always_ff @(posedge clk_i) begin
    if (dwe) begin
      digit_store_q[dcnt_q[DIG_IW-1:0]] <= q_cmd_i.data[3:0];
    end
    if (kwe) begin
      if (kcnt_q[0]) begin
        key_store_q[kwr_idx][7:4] <= q_cmd_i.data[3:0];
      end else begin
        key_store_q[kwr_idx][3:0] <= q_cmd_i.data[3:0];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_value_o  = out_value_q;
  assign out_length_o = out_length_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

@@ hdl/kce_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kce_checker
// Port-level checks on the result stream and configuration port.
// ----------------------------------------------------------------------------
module kce_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast,
  input wire logic        pready
);

  // stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // error result is a single-item message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == kce_pkg::KIND_ERR) |->
      m_axis_tlast && (m_axis_tdata[12:8] == 5'd1))
    else $error("error result malformed");

  // empty digit message only as a lone zero marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[12:8] == 5'd0) |->
      (m_axis_tuser == kce_pkg::KIND_DIGITS) && m_axis_tlast &&
      (m_axis_tdata[7:0] == 8'd0))
    else $error("zero-length result malformed");

  // digit results carry a decimal digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == kce_pkg::KIND_DIGITS) |->
      (m_axis_tdata[7:0] <= 8'd9) && (m_axis_tdata[15:13] == 3'd0))
    else $error("digit result out of range");

  assert property (@(posedge clk_i) pready)
    else $error("pready low");

endmodule

bind keypad_code_entry_and_key_check kce_checker u_kce_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .pready        (pready)
);

`default_nettype wire
